>>> rtl/mesh_face_normal_engine_macros.svh
// Assertion macros shared by the mesh face normal engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MESH_FACE_NORMAL_ENGINE_MACROS_SVH
`define MESH_FACE_NORMAL_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mfn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mfn assertion failed");

`endif

>>> rtl/mfn_pkg.sv
// Shared constants, codes and state types for the mesh face normal engine.
// No dependencies.
`timescale 1ns / 1ps

package mfn_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int CORNER_W     = 16;
    localparam int CMP_W        = (CNT_W > CORNER_W) ? CNT_W : CORNER_W;

    localparam int POS_W   = 24;
    localparam int VTX_W   = 3 * POS_W;
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int NORM_W  = 16;
    localparam int NVEC_W  = 3 * NORM_W;
    localparam int NMEM_W  = NVEC_W + 1;

    localparam int MAG_LIM = 30;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int QUO_W   = 17;
    localparam int NUM_W   = MAG_LIM + 16 + 1;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int REM_W   = DEN_W + 1;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_FACE   = 2'd1,
        FN_READ   = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_DEGEN = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_OUT, S_FETCH_B, S_FETCH_C, S_LATCH_C, S_DIFF,
        S_MUL, S_CHECK, S_NORM, S_WR_A, S_WR_B, S_WR_C
    } t_state;

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DIV_SETUP, N_DIV, N_FIN
    } t_nstate;

endpackage

>>> rtl/mfn_norm.sv
// Normalizer: scales a cross product to a Q1.15 unit vector with a
// bit-serial square root and one reused bit-serial divider. Depends on mfn_pkg.
`timescale 1ns / 1ps

module mfn_norm import mfn_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [CROSS_W-1:0] i_cx,
    input  logic signed [CROSS_W-1:0] i_cy,
    input  logic signed [CROSS_W-1:0] i_cz,
    output logic                      o_done,
    output logic signed [NORM_W-1:0]  o_nx,
    output logic signed [NORM_W-1:0]  o_ny,
    output logic signed [NORM_W-1:0]  o_nz
);

    t_nstate r_st, n_st;

    logic [CROSS_W-1:0]     r_mx, r_my, r_mz;
    logic [2:0]             r_neg;
    logic [4:0]             r_cnt;
    logic [1:0]             r_comp;
    logic [2*MAG_LIM-1:0]   r_sq;
    logic [SUM_W-1:0]       r_sum, r_s, r_root, r_bit;
    logic [DEN_W-1:0]       r_d;
    logic [REM_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_lo, r_q;
    logic                   r_done;
    logic signed [NORM_W-1:0] r_nx, r_ny, r_nz;

    logic [CROSS_W-1:0]     w_big;
    logic [MAG_LIM-1:0]     w_sq_sel, w_div_sel;
    logic [SUM_W-1:0]       w_trial;
    logic [NUM_W-1:0]       w_num;
    logic [REM_W-1:0]       w_shift_rem;
    logic                   w_qbit;
    logic                   w_neg_sel;
    logic [QUO_W-1:0]       w_qneg;
    logic [NORM_W-1:0]      w_res;

    always_comb begin
        w_big = r_mx | r_my | r_mz;
        case (r_cnt[1:0])
            2'd0:    w_sq_sel = r_mx[MAG_LIM-1:0];
            2'd1:    w_sq_sel = r_my[MAG_LIM-1:0];
            default: w_sq_sel = r_mz[MAG_LIM-1:0];
        endcase
        case (r_comp)
            2'd0:    begin w_div_sel = r_mx[MAG_LIM-1:0]; w_neg_sel = r_neg[0]; end
            2'd1:    begin w_div_sel = r_my[MAG_LIM-1:0]; w_neg_sel = r_neg[1]; end
            default: begin w_div_sel = r_mz[MAG_LIM-1:0]; w_neg_sel = r_neg[2]; end
        endcase
        w_trial     = r_root + r_bit;
        w_num       = NUM_W'({w_div_sel, 16'd0}) + NUM_W'(r_root[ROOT_W-1:0]);
        w_shift_rem = {r_rem[REM_W-2:0], r_lo[QUO_W-1]};
        w_qbit      = (w_shift_rem >= REM_W'(r_d));
        w_qneg      = QUO_W'(0) - r_q;
        if (w_neg_sel) begin
            w_res = w_qneg[NORM_W-1:0];
        end else if (r_q[QUO_W-1:NORM_W-1] != '0) begin
            w_res = {1'b0, {(NORM_W-1){1'b1}}};
        end else begin
            w_res = r_q[NORM_W-1:0];
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            N_IDLE:      if (i_start) n_st = N_SHIFT;
            N_SHIFT:     if (w_big[CROSS_W-1:MAG_LIM] == '0) n_st = N_SQ;
            N_SQ:        if (r_cnt == 5'd3) n_st = N_ROOT;
            N_ROOT:      if (r_cnt == 5'd31) n_st = N_DIV_SETUP;
            N_DIV_SETUP: n_st = N_DIV;
            N_DIV:       if (r_cnt == 5'd0) n_st = N_FIN;
            N_FIN:       n_st = (r_comp == 2'd2) ? N_IDLE : N_DIV_SETUP;
            default:     n_st = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= N_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == N_FIN) && (r_comp == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            N_IDLE: begin
                r_mx   <= i_cx[CROSS_W-1] ? CROSS_W'(-i_cx) : i_cx;
                r_my   <= i_cy[CROSS_W-1] ? CROSS_W'(-i_cy) : i_cy;
                r_mz   <= i_cz[CROSS_W-1] ? CROSS_W'(-i_cz) : i_cz;
                r_neg  <= {i_cz[CROSS_W-1], i_cy[CROSS_W-1], i_cx[CROSS_W-1]};
                r_cnt  <= '0;
                r_sum  <= '0;
                r_comp <= '0;
            end
            N_SHIFT: begin
                // drop one bit from all three until the largest fits
                if (w_big[CROSS_W-1:MAG_LIM] != '0) begin
                    r_mx <= r_mx >> 1;
                    r_my <= r_my >> 1;
                    r_mz <= r_mz >> 1;
                end
            end
            N_SQ: begin
                r_sq <= w_sq_sel * w_sq_sel;
                if (r_cnt != 5'd0) r_sum <= r_sum + SUM_W'(r_sq);
                if (r_cnt == 5'd3) begin
                    r_s    <= r_sum + SUM_W'(r_sq);
                    r_root <= '0;
                    r_bit  <= SUM_W'(1) << (SUM_W - 2);
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            N_ROOT: begin
                if (r_s >= w_trial) begin
                    r_s    <= r_s - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            N_DIV_SETUP: begin
                r_d   <= {r_root[ROOT_W-1:0], 1'b0};
                r_rem <= REM_W'(w_num[NUM_W-1:QUO_W]);
                r_lo  <= w_num[QUO_W-1:0];
                r_q   <= '0;
                r_cnt <= 5'(QUO_W - 1);
            end
            N_DIV: begin
                r_rem <= w_qbit ? (w_shift_rem - REM_W'(r_d)) : w_shift_rem;
                r_q   <= {r_q[QUO_W-2:0], w_qbit};
                r_lo  <= r_lo << 1;
                r_cnt <= r_cnt - 5'd1;
            end
            N_FIN: begin
                case (r_comp)
                    2'd0:    r_nx <= w_res;
                    2'd1:    r_ny <= w_res;
                    default: r_nz <= w_res;
                endcase
                r_comp <= r_comp + 2'd1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_nx   = r_nx;
    assign o_ny   = r_ny;
    assign o_nz   = r_nz;

endmodule

>>> rtl/mesh_face_normal_engine.sv
// Top level of the mesh face normal engine: vertex and normal memories,
// command sequencer and cross product. Depends on mfn_pkg, mfn_norm and the macros header.
`timescale 1ns / 1ps

// Issue a command by raising start while busy is low; that edge takes the
// transaction. Every command yields exactly one result, shown on the o_
// result ports for a single cycle with o_done high; the receiver cannot
// stall, so capture it then. Append, clear and any command refused for a
// bad index or a full store answer in the cycle after acceptance and keep
// busy low. A read holds busy while the registered normal memory read port
// is read. A face answers in the first cycle with busy low: three vertex
// reads through the one read port of the vertex memory, six products through
// one shared multiplier, range scaling, a 32-step bit-serial square root,
// three 17-step bit-serial divides and three writes through the normal memory
// write port; a zero cross product answers ST_DEGEN after the products. No
// clearing pass is needed after reset or clear: an append marks its normal
// entry unwritten, and only appended entries can be addressed.
module mesh_face_normal_engine import mfn_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_func,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [CORNER_W-1:0]      i_corner_a,
    input  logic [CORNER_W-1:0]      i_corner_b,
    input  logic [CORNER_W-1:0]      i_corner_c,
    output logic                     o_done,
    output logic signed [NORM_W-1:0] o_norm_x,
    output logic signed [NORM_W-1:0] o_norm_y,
    output logic signed [NORM_W-1:0] o_norm_z,
    output logic [1:0]               o_status
);

`include "mesh_face_normal_engine_macros.svh"

    // Memories: positions {z,y,x} and normals {written, z, y, x}.
    logic [VTX_W-1:0]  m_vtx [MAX_VERTICES];
    logic [NMEM_W-1:0] m_nrm [MAX_VERTICES];
    logic [VTX_W-1:0]  r_vtx_rd;
    logic [NMEM_W-1:0] r_nrm_rd;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_ia, r_ib, r_ic;
    logic [VTX_W-1:0] r_va, r_vb;
    logic signed [DIFF_W-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic [2:0] r_step;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CROSS_W-1:0] r_crx, r_cry, r_crz;
    logic [NVEC_W-1:0] r_nrm;

    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [NVEC_W-1:0] r_out, n_out;

    logic [CORNER_W-1:0] w_ia_m1, w_ib_m1, w_ic_m1;
    logic w_a_ok, w_b_ok, w_c_ok, w_full;
    logic              w_vtx_we;
    logic [IDX_W-1:0]  w_vtx_raddr;
    logic              w_nrm_we;
    logic [IDX_W-1:0]  w_nrm_waddr;
    logic [NMEM_W-1:0] w_nrm_wdata;
    logic              w_norm_start;
    logic signed [DIFF_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_mul;
    logic signed [CROSS_W-1:0] w_prod_ext;
    logic [2:0]                w_acc;
    logic                      u_done;
    logic signed [NORM_W-1:0]  u_nx, u_ny, u_nz;

    function automatic logic signed [DIFF_W-1:0] pdiff(
        input logic [POS_W-1:0] p,
        input logic [POS_W-1:0] q
    );
        return {p[POS_W-1], p} - {q[POS_W-1], q};
    endfunction

    // Index checks: 1-based, nonzero and within the current count.
    always_comb begin
        w_ia_m1 = i_corner_a - CORNER_W'(1);
        w_ib_m1 = i_corner_b - CORNER_W'(1);
        w_ic_m1 = i_corner_c - CORNER_W'(1);
        w_a_ok  = (i_corner_a != '0) && (CMP_W'(i_corner_a) <= CMP_W'(r_count));
        w_b_ok  = (i_corner_b != '0) && (CMP_W'(i_corner_b) <= CMP_W'(r_count));
        w_c_ok  = (i_corner_c != '0) && (CMP_W'(i_corner_c) <= CMP_W'(r_count));
        w_full  = (r_count == CNT_W'(MAX_VERTICES));
    end

    // Sequencer: next state, memory controls and result.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_done       = 1'b0;
        n_status     = ST_OK;
        n_out        = '0;
        w_vtx_we     = 1'b0;
        w_nrm_we     = 1'b0;
        w_nrm_waddr  = r_count[IDX_W-1:0];
        w_nrm_wdata  = '0;
        w_norm_start = 1'b0;
        case (r_state)
            S_FETCH_B: w_vtx_raddr = r_ib;
            S_FETCH_C: w_vtx_raddr = r_ic;
            S_LATCH_C: w_vtx_raddr = r_ic;
            default:   w_vtx_raddr = w_ia_m1[IDX_W-1:0];
        endcase
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_func)
                        FN_APPEND: begin
                            n_done = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_vtx_we = 1'b1;
                                w_nrm_we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        FN_CLEAR: begin
                            n_done  = 1'b1;
                            n_count = '0;
                        end
                        FN_READ: begin
                            if (w_a_ok) begin
                                n_state = S_RD_OUT;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                            end
                        end
                        FN_FACE: begin
                            if (w_a_ok && w_b_ok && w_c_ok) begin
                                n_state = S_FETCH_B;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_OUT: begin
                n_done  = 1'b1;
                n_out   = r_nrm_rd[NVEC_W] ? r_nrm_rd[NVEC_W-1:0] : '0;
                n_state = S_IDLE;
            end
            S_FETCH_B: n_state = S_FETCH_C;
            S_FETCH_C: n_state = S_LATCH_C;
            S_LATCH_C: n_state = S_DIFF;
            S_DIFF:    n_state = S_MUL;
            S_MUL:     if (r_step == 3'd6) n_state = S_CHECK;
            S_CHECK: begin
                if (r_crx == '0 && r_cry == '0 && r_crz == '0) begin
                    n_done   = 1'b1;
                    n_status = ST_DEGEN;
                    n_state  = S_IDLE;
                end else begin
                    w_norm_start = 1'b1;
                    n_state      = S_NORM;
                end
            end
            S_NORM: if (u_done) n_state = S_WR_A;
            S_WR_A: begin
                w_nrm_we    = 1'b1;
                w_nrm_waddr = r_ia;
                w_nrm_wdata = {1'b1, r_nrm};
                n_state     = S_WR_B;
            end
            S_WR_B: begin
                w_nrm_we    = 1'b1;
                w_nrm_waddr = r_ib;
                w_nrm_wdata = {1'b1, r_nrm};
                n_state     = S_WR_C;
            end
            S_WR_C: begin
                w_nrm_we    = 1'b1;
                w_nrm_waddr = r_ic;
                w_nrm_wdata = {1'b1, r_nrm};
                n_done      = 1'b1;
                n_out       = r_nrm;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Vertex memory: one write port for append, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_vtx_we) begin
            m_vtx[r_count[IDX_W-1:0]] <= {i_pos_z, i_pos_y, i_pos_x};
        end
        r_vtx_rd <= m_vtx[w_vtx_raddr];
    end

    // Normal memory: append clears the written flag, face writes set it.
    always_ff @(posedge i_clk) begin
        if (w_nrm_we) begin
            m_nrm[w_nrm_waddr] <= w_nrm_wdata;
        end
        r_nrm_rd <= m_nrm[w_ia_m1[IDX_W-1:0]];
    end

    // Shared multiplier; each product is registered before accumulation.
    always_comb begin
        case (r_step)
            3'd0:    begin w_mul_a = r_uy; w_mul_b = r_vz; end
            3'd1:    begin w_mul_a = r_uz; w_mul_b = r_vy; end
            3'd2:    begin w_mul_a = r_uz; w_mul_b = r_vx; end
            3'd3:    begin w_mul_a = r_ux; w_mul_b = r_vz; end
            3'd4:    begin w_mul_a = r_ux; w_mul_b = r_vy; end
            default: begin w_mul_a = r_uy; w_mul_b = r_vx; end
        endcase
        w_mul      = w_mul_a * w_mul_b;
        w_prod_ext = {r_prod[PROD_W-1], r_prod};
        w_acc      = r_step - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ia <= w_ia_m1[IDX_W-1:0];
                r_ib <= w_ib_m1[IDX_W-1:0];
                r_ic <= w_ic_m1[IDX_W-1:0];
            end
            S_FETCH_B: r_va <= r_vtx_rd;
            S_FETCH_C: r_vb <= r_vtx_rd;
            S_DIFF: begin
                // r_vtx_rd still holds corner C here
                r_ux   <= pdiff(r_vb[POS_W-1:0], r_va[POS_W-1:0]);
                r_uy   <= pdiff(r_vb[2*POS_W-1:POS_W], r_va[2*POS_W-1:POS_W]);
                r_uz   <= pdiff(r_vb[VTX_W-1:2*POS_W], r_va[VTX_W-1:2*POS_W]);
                r_vx   <= pdiff(r_vtx_rd[POS_W-1:0], r_va[POS_W-1:0]);
                r_vy   <= pdiff(r_vtx_rd[2*POS_W-1:POS_W], r_va[2*POS_W-1:POS_W]);
                r_vz   <= pdiff(r_vtx_rd[VTX_W-1:2*POS_W], r_va[VTX_W-1:2*POS_W]);
                r_step <= '0;
            end
            S_MUL: begin
                r_prod <= w_mul;
                r_step <= r_step + 3'd1;
                if (r_step != 3'd0) begin
                    case (w_acc)
                        3'd0:    r_crx <= w_prod_ext;
                        3'd1:    r_crx <= r_crx - w_prod_ext;
                        3'd2:    r_cry <= w_prod_ext;
                        3'd3:    r_cry <= r_cry - w_prod_ext;
                        3'd4:    r_crz <= w_prod_ext;
                        default: r_crz <= r_crz - w_prod_ext;
                    endcase
                end
            end
            S_NORM: if (u_done) r_nrm <= {u_nz, u_ny, u_nx};
            default: ;
        endcase
    end

    mfn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_norm_start),
        .i_cx    (r_crx),
        .i_cy    (r_cry),
        .i_cz    (r_crz),
        .o_done  (u_done),
        .o_nx    (u_nx),
        .o_ny    (u_ny),
        .o_nz    (u_nz)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_norm_x = r_out[NORM_W-1:0];
    assign o_norm_y = r_out[2*NORM_W-1:NORM_W];
    assign o_norm_z = r_out[NVEC_W-1:2*NORM_W];

    `MFN_ASSERT_NEXT(a_append_count, i_clk, i_rst_n, start && !busy && i_func == FN_APPEND && !w_full, r_count == $past(r_count) + CNT_W'(1) && o_done && o_status == ST_OK)
    `MFN_ASSERT_NEXT(a_clear_result, i_clk, i_rst_n, start && !busy && i_func == FN_CLEAR, r_count == '0 && o_done && o_status == ST_OK)
    `MFN_ASSERT_IMPL(a_norm_done_wait, i_clk, i_rst_n, u_done, r_state == S_NORM)
    `MFN_ASSERT_IMPL(a_flag_write_face, i_clk, i_rst_n, w_nrm_we && w_nrm_wdata[NVEC_W], r_state == S_WR_A || r_state == S_WR_B || r_state == S_WR_C)

endmodule
